// ===== rtl/core/length_prefixed_message_ring_defines.svh =====
// assertion macros used by the message ring engine
`ifndef LENGTH_PREFIXED_MESSAGE_RING_DEFINES_SVH
`define LENGTH_PREFIXED_MESSAGE_RING_DEFINES_SVH

// condition that must hold at every edge out of reset
`define LPMR_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define LPMR_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LPMR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lpmr_pkg.sv =====
// shared types, constants and helpers for the message ring
package lpmr_pkg;

  localparam int CAPACITY_DEF     = 4096;
  localparam int HEADER_BYTES_DEF = 4;
  localparam int LEN_W            = 12;
  localparam int DATA_W           = 8;
  localparam int STAT_W           = 3;
  localparam int IDX_W            = 3;
  localparam int QUEUE_DEPTH      = 2;
  localparam int QIDX_W           = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_PUSH_START = 2'd0,
    OP_PUSH_BYTE  = 2'd1,
    OP_POP_START  = 2'd2,
    OP_POP_BYTE   = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 3'd0,
    STAT_EMPTY = 3'd1,
    STAT_SMALL = 3'd2,
    STAT_FULL  = 3'd3,
    STAT_NONE  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_CHECK,
    S_HDR_WR,
    S_POP_CHECK,
    S_HDR_RD,
    S_POP_LEN,
    S_RD_WAIT,
    S_RESULT
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] data_byte;
    logic [LEN_W-1:0]  msg_length;
    logic [LEN_W-1:0]  out_capacity;
  } item_t;

  function automatic op_t classify(input logic [1:0] cmd);
    op_t op;
    case (cmd)
      2'd0:    op = OP_PUSH_START;
      2'd1:    op = OP_PUSH_BYTE;
      2'd2:    op = OP_POP_START;
      default: op = OP_POP_BYTE;
    endcase
    return op;
  endfunction

  // little-endian length header byte
  function automatic logic [DATA_W-1:0] header_byte(input logic [LEN_W-1:0] mlen,
                                                    input logic [IDX_W-1:0] idx);
    logic [DATA_W-1:0] b;
    case (idx)
      3'd0:    b = mlen[7:0];
      3'd1:    b = {4'b0000, mlen[11:8]};
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/core/lpmr_cmd_queue.sv =====
// front end: accepts and classifies commands into a short queue
module lpmr_cmd_queue
  import lpmr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           cmd,
  input  logic [DATA_W-1:0]    data_byte,
  input  logic [LEN_W-1:0]     msg_length,
  input  logic [LEN_W-1:0]     out_capacity,
  output logic                 q_valid,
  output item_t                q_item,
  input  logic                 q_pop
);

  item_t             slots [QUEUE_DEPTH];
  logic [QIDX_W-1:0] wr_idx;
  logic [QIDX_W-1:0] rd_idx;
  logic [QIDX_W:0]   count;
  logic              push;

  assign in_stall = (count == (QIDX_W+1)'(QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign q_item   = slots[rd_idx];
  assign push     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (push) wr_idx <= wr_idx + 1'b1;
      if (q_pop) rd_idx <= rd_idx + 1'b1;
      if (push && !q_pop) count <= count + 1'b1;
      else if (!push && q_pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_idx] <= '{op: classify(cmd), data_byte: data_byte,
                         msg_length: msg_length, out_capacity: out_capacity};
    end
  end

endmodule

// ===== rtl/core/lpmr_engine.sv =====
// back end: ring memory, pointers and command sequencer with output register
`include "length_prefixed_message_ring_defines.svh"
module lpmr_engine
  import lpmr_pkg::*;
#(
  parameter int CAPACITY     = CAPACITY_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] status,
  output logic [DATA_W-1:0] data_out,
  output logic [LEN_W-1:0]  length_out,
  output logic              last,
  output logic              is_empty
);

  localparam int PTR_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int N_W    = (PTR_W > LEN_W) ? PTR_W : LEN_W;
  localparam int SUM_W  = N_W + 1;
  localparam int FSUM_W = N_W + 2;

  function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                           input logic [N_W-1:0] n);
    logic [SUM_W-1:0] s;
    s = SUM_W'(p) + SUM_W'(n);
    if (s >= SUM_W'(CAPACITY)) s = s - SUM_W'(CAPACITY);
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] free_add(input logic [CNT_W-1:0] f,
                                                input logic [N_W-1:0] n);
    logic [FSUM_W-1:0] s;
    s = FSUM_W'(f) + FSUM_W'(n);
    if (s > FSUM_W'(CAPACITY)) s = FSUM_W'(CAPACITY);
    return s[CNT_W-1:0];
  endfunction

  state_t            state, state_next;
  logic [PTR_W-1:0]  write_ptr, commit_ptr, read_ptr;
  logic [CNT_W-1:0]  free_count;
  logic [LEN_W-1:0]  push_left, pop_left;
  logic              push_dropping;
  logic [IDX_W-1:0]  hdr_idx;
  item_t             cur;
  logic [LEN_W-1:0]  hdr_len;
  status_t           res_status;
  logic [DATA_W-1:0] res_data;
  logic [LEN_W-1:0]  res_len;
  logic              res_last;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_data;
  logic              mem_we;
  logic [PTR_W-1:0]  mem_addr;
  logic [DATA_W-1:0] mem_wdata;
  logic              out_load;

  logic [PTR_W-1:0]  wr_inc, rd_inc;
  logic [PTR_W-1:0]  pend;
  logic [FSUM_W-1:0] need;
  logic              push_reject;
  logic              hdr_wr_last;
  logic              hdr_rd_done;
  logic [IDX_W-1:0]  byte_sel;
  logic              push_write;
  logic              pop_read;

  assign wr_inc = adv(write_ptr, N_W'(1));
  assign rd_inc = adv(read_ptr, N_W'(1));

  // bytes of an unfinished push, given back on restart
  always_comb begin
    if (write_ptr >= commit_ptr) pend = write_ptr - commit_ptr;
    else pend = PTR_W'((PTR_W+1)'(write_ptr) + (PTR_W+1)'(CAPACITY) - (PTR_W+1)'(commit_ptr));
  end

  assign need        = FSUM_W'(HEADER_BYTES) + FSUM_W'(cur.msg_length);
  assign push_reject = ((HEADER_BYTES == 1) && (cur.msg_length[11:8] != '0)) ||
                       (need >= FSUM_W'(free_count));
  assign hdr_wr_last = (hdr_idx == IDX_W'(HEADER_BYTES - 1));
  assign hdr_rd_done = (hdr_idx == IDX_W'(HEADER_BYTES));
  assign byte_sel    = hdr_idx - 1'b1;
  assign push_write  = (q_item.op == OP_PUSH_BYTE) && !push_dropping && (push_left != '0);
  assign pop_read    = (q_item.op == OP_POP_BYTE) && (pop_left != '0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            OP_PUSH_START: state_next = S_PUSH_CHECK;
            OP_POP_START:  state_next = S_POP_CHECK;
            OP_POP_BYTE:   state_next = pop_read ? S_RD_WAIT : S_RESULT;
            default:       state_next = S_RESULT;
          endcase
        end
      end
      S_PUSH_CHECK: state_next = push_reject ? S_RESULT : S_HDR_WR;
      S_HDR_WR:     if (hdr_wr_last) state_next = S_RESULT;
      S_POP_CHECK:  state_next = (read_ptr == commit_ptr) ? S_RESULT : S_HDR_RD;
      S_HDR_RD:     if (hdr_rd_done) state_next = S_POP_LEN;
      S_POP_LEN:    state_next = S_RESULT;
      S_RD_WAIT:    state_next = S_RESULT;
      S_RESULT:     if (!out_valid || !out_stall) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // memory port and handshake controls
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = read_ptr;
    mem_wdata = '0;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    case (state)
      S_IDLE: begin
        q_pop = q_valid;
        if (q_valid && push_write) begin
          mem_we    = 1'b1;
          mem_addr  = write_ptr;
          mem_wdata = q_item.data_byte;
        end
      end
      S_HDR_WR: begin
        mem_we    = 1'b1;
        mem_addr  = write_ptr;
        mem_wdata = header_byte(cur.msg_length, hdr_idx);
      end
      S_RESULT: out_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_data <= mem[mem_addr];
  end

  // ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      write_ptr     <= '0;
      commit_ptr    <= '0;
      read_ptr      <= '0;
      free_count    <= CNT_W'(CAPACITY);
      push_left     <= '0;
      pop_left      <= '0;
      push_dropping <= 1'b0;
      hdr_idx       <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            case (q_item.op)
              OP_PUSH_START: begin
                write_ptr  <= commit_ptr;
                free_count <= free_add(free_count, N_W'(pend));
                push_left  <= '0;
              end
              OP_PUSH_BYTE: begin
                if (push_write) begin
                  write_ptr  <= wr_inc;
                  if (free_count != '0) free_count <= free_count - 1'b1;
                  push_left  <= push_left - 1'b1;
                  if (push_left == LEN_W'(1)) commit_ptr <= wr_inc;
                end
              end
              OP_POP_START: begin
                if (pop_left != '0) begin
                  read_ptr   <= adv(read_ptr, N_W'(pop_left));
                  free_count <= free_add(free_count, N_W'(pop_left));
                  pop_left   <= '0;
                end
              end
              default: begin
                if (pop_read) begin
                  read_ptr <= rd_inc;
                  if (free_count < CNT_W'(CAPACITY)) free_count <= free_count + 1'b1;
                  pop_left <= pop_left - 1'b1;
                end
              end
            endcase
          end
        end
        S_PUSH_CHECK: begin
          push_dropping <= push_reject;
          hdr_idx       <= '0;
          if (!push_reject) push_left <= cur.msg_length;
        end
        S_HDR_WR: begin
          write_ptr <= wr_inc;
          if (free_count != '0) free_count <= free_count - 1'b1;
          hdr_idx <= hdr_idx + 1'b1;
          // zero-length message commits with its header
          if (hdr_wr_last && (cur.msg_length == '0)) commit_ptr <= wr_inc;
        end
        S_POP_CHECK: hdr_idx <= '0;
        S_HDR_RD: begin
          if (!hdr_rd_done) begin
            read_ptr <= rd_inc;
            if (free_count < CNT_W'(CAPACITY)) free_count <= free_count + 1'b1;
            hdr_idx <= hdr_idx + 1'b1;
          end
        end
        S_POP_LEN: begin
          if (cur.out_capacity < hdr_len) begin
            read_ptr   <= adv(read_ptr, N_W'(hdr_len));
            free_count <= free_add(free_count, N_W'(hdr_len));
          end else begin
            pop_left <= hdr_len;
          end
        end
        default: ;
      endcase
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          cur        <= q_item;
          res_status <= STAT_OK;
          res_data   <= '0;
          res_len    <= '0;
          res_last   <= 1'b0;
          hdr_len    <= '0;
          if (q_item.op == OP_PUSH_BYTE) begin
            if (push_dropping) res_status <= STAT_FULL;
            else if (push_left == '0) res_status <= STAT_NONE;
            else res_last <= (push_left == LEN_W'(1));
          end else if (q_item.op == OP_POP_BYTE) begin
            if (pop_left == '0) res_status <= STAT_NONE;
            else res_last <= (pop_left == LEN_W'(1));
          end
        end
      end
      S_PUSH_CHECK: if (push_reject) res_status <= STAT_FULL;
      S_POP_CHECK:  if (read_ptr == commit_ptr) res_status <= STAT_EMPTY;
      S_HDR_RD: begin
        if (hdr_idx != '0) begin
          case (byte_sel)
            3'd0:    hdr_len[7:0]  <= rd_data;
            3'd1:    hdr_len[11:8] <= rd_data[3:0];
            default: ;
          endcase
        end
      end
      S_POP_LEN: begin
        if (cur.out_capacity < hdr_len) res_status <= STAT_SMALL;
        else res_len <= hdr_len;
      end
      S_RD_WAIT: res_data <= rd_data;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      status     <= res_status;
      data_out   <= res_data;
      length_out <= res_len;
      last       <= res_last;
      is_empty   <= (adv(read_ptr, N_W'(pop_left)) == commit_ptr);
    end
  end

  `LPMR_ASSERT_ALWAYS(a_free_bound, clk, rst, free_count <= CNT_W'(CAPACITY), "free count over capacity")
  `LPMR_ASSERT_IMPLIES(a_write_state, clk, rst, mem_we, (state == S_IDLE) || (state == S_HDR_WR), "ring write outside a push")
  `LPMR_ASSERT_NEXT(a_hdr_rd_end, clk, rst, (state == S_HDR_RD) && hdr_rd_done, state == S_POP_LEN, "header read did not finish")
  `LPMR_ASSERT_NEXT(a_out_load, clk, rst, out_load, out_valid, "loaded result not presented")

endmodule

// ===== rtl/core/length_prefixed_message_ring.sv =====
// a taken command steps through engine states, S_RESULT loading the output register:
// push_byte S_IDLE, S_RESULT; pop_byte S_IDLE, S_RD_WAIT (only with body left), S_RESULT;
// push_start S_IDLE, S_PUSH_CHECK, S_HDR_WR per header byte (not if rejected), S_RESULT;
// pop_start S_IDLE, S_POP_CHECK, S_HDR_RD per header byte plus a final one and S_POP_LEN
// (neither if empty), S_RESULT; each header byte uses the single ring memory port; S_RESULT
// holds on a result stall; one item is worked at a time while the queue takes up to two more
// rst (synchronous) empties the ring and queue; the byte store itself is not cleared
module length_prefixed_message_ring
  import lpmr_pkg::*;
#(
  parameter int CAPACITY     = CAPACITY_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // command channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        cmd,
  input  logic [DATA_W-1:0] data_byte,
  input  logic [LEN_W-1:0]  msg_length,
  input  logic [LEN_W-1:0]  out_capacity,
  // result channel, one transaction per command
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] status,
  output logic [DATA_W-1:0] data_out,
  output logic [LEN_W-1:0]  length_out,
  output logic              last,
  output logic              is_empty
);

  // queue to engine hand-off
  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // front end: decode the command and buffer it so the source is not held
  // while the engine works through header bytes
  lpmr_cmd_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .data_byte    (data_byte),
    .msg_length   (msg_length),
    .out_capacity (out_capacity),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  // back end: byte ring with write, commit and read pointers; a message is
  // visible to pop only once the commit pointer moves past its last byte
  lpmr_engine #(
    .CAPACITY     (CAPACITY),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .data_out   (data_out),
    .length_out (length_out),
    .last       (last),
    .is_empty   (is_empty)
  );

endmodule
